FILE: hdl/chip8_pkg.sv
// Shared types, opcode constants and font table for the CHIP-8 instruction core.
package chip8_pkg;

    localparam int ADDR_W     = 12;
    localparam int MEM_BYTES  = 4096;
    localparam int FONT_BYTES = 80;
    localparam logic [ADDR_W-1:0] DISP_BASE = 12'd80;

    // Item codes
    typedef enum logic [2:0] {
        OP_EXEC  = 3'd0,
        OP_TICK  = 3'd1,
        OP_KEY   = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_SETPC = 3'd5
    } item_op_t;

    // Opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JP   = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SE   = 4'h3;
    localparam logic [3:0] OPG_SNE  = 4'h4;
    localparam logic [3:0] OPG_SEV  = 4'h5;
    localparam logic [3:0] OPG_LD   = 4'h6;
    localparam logic [3:0] OPG_ADD  = 4'h7;
    localparam logic [3:0] OPG_ALU  = 4'h8;
    localparam logic [3:0] OPG_SNEV = 4'h9;
    localparam logic [3:0] OPG_LDI  = 4'hA;
    localparam logic [3:0] OPG_JPV  = 4'hB;
    localparam logic [3:0] OPG_RND  = 4'hC;
    localparam logic [3:0] OPG_DRW  = 4'hD;
    localparam logic [3:0] OPG_KEY  = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    // 8xyN sub-operations
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [11:0] NNN_CLS = 12'h0E0;
    localparam logic [11:0] NNN_RET = 12'h0EE;

    localparam logic [7:0] KK_SKP   = 8'h9E;
    localparam logic [7:0] KK_SKNP  = 8'hA1;
    localparam logic [7:0] KK_LDDT  = 8'h07;
    localparam logic [7:0] KK_WAITK = 8'h0A;
    localparam logic [7:0] KK_SETDT = 8'h15;
    localparam logic [7:0] KK_SETST = 8'h18;
    localparam logic [7:0] KK_ADDI  = 8'h1E;
    localparam logic [7:0] KK_FONT  = 8'h29;
    localparam logic [7:0] KK_BCD   = 8'h33;
    localparam logic [7:0] KK_STORE = 8'h55;
    localparam logic [7:0] KK_LOAD  = 8'h65;

    // Multi-cycle work an instruction needs after its execute step
    typedef enum logic [2:0] {
        K_DONE,
        K_CLS,
        K_DRAW,
        K_BCD,
        K_STORE,
        K_LOAD
    } exec_kind_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_F_HI,
        ST_F_LO,
        ST_F_DEC,
        ST_VX,
        ST_VY,
        ST_EXEC,
        ST_CLS,
        ST_D_SPR,
        ST_D_A,
        ST_D_AW,
        ST_D_BW,
        ST_BCD,
        ST_STORE,
        ST_LD_RD,
        ST_LD_WR,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        ctrl_state_t step;
        logic        latch;
        logic        out_load;
    } dp_cmd_t;

    typedef struct packed {
        item_op_t   item_op;
        logic       waiting;
        exec_kind_t kind;
        logic       clr_last;
        logic       cls_last;
        logic       cnt_zero;
        logic       blk_last;
        logic       bcd_last;
    } dp_status_t;

    // Hex font, five rows of four pixels per glyph
    localparam logic [19:0] GLYPH [16] = '{
        20'hF999F, 20'h26227, 20'hF1F8F, 20'hF1F1F,
        20'h99F11, 20'hF8F1F, 20'hF8F9F, 20'hF1244,
        20'hF9F9F, 20'hF9F1F, 20'hF9F99, 20'hE9E9E,
        20'hF888F, 20'hE999E, 20'hF8F8F, 20'hF8F88
    };

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] b;
        b = '0;
        for (int g = 0; g < 16; g++) begin
            for (int r = 0; r < 5; r++) begin
                if (a == 7'(g * 5 + r)) begin
                    b = {GLYPH[g][19 - 4 * r -: 4], 4'h0};
                end
            end
        end
        return b;
    endfunction

endpackage

FILE: hdl/chip8_item_if.sv
// Input item channel: valid/ready plus item payload.
interface chip8_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [3:0]  key_code;
    logic        key_down;
    logic [11:0] mem_addr;
    logic [7:0]  mem_byte;
    logic [7:0]  random_byte;

    modport source (output valid, op, key_code, key_down, mem_addr, mem_byte, random_byte,
                    input ready);
    modport sink   (input valid, op, key_code, key_down, mem_addr, mem_byte, random_byte,
                    output ready);
endinterface

FILE: hdl/chip8_result_if.sv
// Result channel: valid/ready plus result payload.
interface chip8_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [11:0] pc_value;
    logic        waiting;
    logic        sound_active;

    modport source (output valid, read_data, pc_value, waiting, sound_active, input ready);
    modport sink   (input valid, read_data, pc_value, waiting, sound_active, output ready);
endinterface

FILE: hdl/chip8_ctrl.sv
// Sequencer state machine for the CHIP-8 core.
module chip8_ctrl
    import chip8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR:    if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (status.item_op == OP_EXEC && !status.waiting) state_next = ST_F_HI;
                else                                               state_next = ST_DONE;
            end
            ST_F_HI:     state_next = ST_F_LO;
            ST_F_LO:     state_next = ST_F_DEC;
            ST_F_DEC:    state_next = ST_VX;
            ST_VX:       state_next = ST_VY;
            ST_VY:       state_next = ST_EXEC;
            ST_EXEC:
            begin
                case (status.kind)
                    K_CLS:   state_next = ST_CLS;
                    K_DRAW:  state_next = ST_D_SPR;
                    K_BCD:   state_next = ST_BCD;
                    K_STORE: state_next = ST_STORE;
                    K_LOAD:  state_next = ST_LD_RD;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_CLS:      if (status.cls_last) state_next = ST_DONE;
            ST_D_SPR:    state_next = ST_D_A;
            ST_D_A:      state_next = ST_D_AW;
            ST_D_AW:     state_next = ST_D_BW;
            ST_D_BW:     state_next = status.cnt_zero ? ST_DONE : ST_D_SPR;
            ST_BCD:      if (status.bcd_last) state_next = ST_DONE;
            ST_STORE:    if (status.blk_last) state_next = ST_DONE;
            ST_LD_RD:    state_next = ST_LD_WR;
            ST_LD_WR:    state_next = status.blk_last ? ST_DONE : ST_LD_RD;
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
                if (out_load) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)       out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
        else                out_valid_next = out_valid_reg;
    end

    assign out_valid    = out_valid_reg;
    assign cmd.step     = state_reg;
    assign cmd.latch    = in_ready && in_valid;
    assign cmd.out_load = out_load;

endmodule

FILE: hdl/chip8_dp.sv
// CHIP-8 datapath: memory, register file, stack, timers, keys and result register.
module chip8_dp
    import chip8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [2:0]  op,
    input  logic [3:0]  key_code,
    input  logic        key_down,
    input  logic [11:0] mem_addr,
    input  logic [7:0]  mem_byte,
    input  logic [7:0]  random_byte,
    output logic [7:0]  read_data,
    output logic [11:0] pc_value,
    output logic        waiting,
    output logic        sound_active
);

    // Main memory, one write and one registered read port
    logic [7:0]  mem [MEM_BYTES];
    logic        mem_we, mem_re;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, rd_q;

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re) rd_q <= mem[mem_raddr];
    end

    // Architectural state
    logic [7:0]  v_reg [16];
    logic [11:0] stk_reg [16];
    logic [11:0] pc_reg, pc_next, i_reg, i_next;
    logic [3:0]  sp_reg, sp_next, tgt_reg, tgt_next;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic [15:0] keys_reg, keys_next;
    logic        wait_reg, wait_next;

    // Working registers
    logic [11:0] cnt_reg, cnt_next;
    logic [15:0] opc_reg, opc_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next, spr_reg, spr_next;
    logic        hit_reg, hit_next;

    // Latched item
    item_op_t    it_op_reg;
    logic [3:0]  it_key_reg;
    logic        it_down_reg;
    logic [11:0] it_addr_reg;
    logic [7:0]  it_byte_reg, it_rnd_reg;

    // Result register
    logic [7:0]  rd_out_reg;
    logic [11:0] pc_out_reg;
    logic        wait_out_reg, snd_out_reg;

    // Write ports of register file and stack
    logic        rf_we, vf_we, stk_we;
    logic [3:0]  rf_waddr, rf_raddr, stk_waddr;
    logic [7:0]  rf_wdata, vf_wdata, rf_rdata;
    logic [11:0] stk_wdata;

    // Decode
    logic [3:0]  op_hi, x, y, n;
    logic [7:0]  kk;
    logic [11:0] nnn, pc2, pc4;
    exec_kind_t  kind;

    assign op_hi = opc_reg[15:12];
    assign x     = opc_reg[11:8];
    assign y     = opc_reg[7:4];
    assign n     = opc_reg[3:0];
    assign kk    = opc_reg[7:0];
    assign nnn   = opc_reg[11:0];
    assign pc2   = pc_reg + 12'd2;
    assign pc4   = pc_reg + 12'd4;
    assign rf_rdata = v_reg[rf_raddr];

    always_comb
    begin
        kind = K_DONE;
        case (op_hi)
            OPG_SYS:  if (nnn == NNN_CLS) kind = K_CLS;
            OPG_DRW:  if (n != 4'h0) kind = K_DRAW;
            OPG_MISC:
            begin
                case (kk)
                    KK_BCD:   kind = K_BCD;
                    KK_STORE: kind = K_STORE;
                    KK_LOAD:  kind = K_LOAD;
                    default:  kind = K_DONE;
                endcase
            end
            default:  kind = K_DONE;
        endcase
    end

    // Sprite geometry: display byte index is {row, column byte}
    logic [4:0]  row5;
    logic [11:0] addr_a, addr_b;
    logic [15:0] spr_sh;
    logic [7:0]  bits_a, bits_b;
    logic        hit_b;

    assign row5   = vy_reg[4:0] + cnt_reg[4:0];
    assign addr_a = DISP_BASE + {4'h0, row5, vx_reg[5:3]};
    assign addr_b = DISP_BASE + {4'h0, row5, 3'(vx_reg[5:3] + 3'd1)};
    assign spr_sh = {spr_reg, 8'h00} >> vx_reg[2:0];
    assign bits_a = spr_sh[15:8];
    assign bits_b = spr_sh[7:0];
    assign hit_b  = hit_reg | (|(rd_q & bits_b));

    // Decimal digits of Vx; tens via reciprocal multiply (valid below 100)
    logic [1:0]  hund;
    logic [7:0]  rem100;
    logic [14:0] tens_prod;
    logic [3:0]  tens, ones;
    logic [7:0]  bcd_digit;

    always_comb
    begin
        if (vx_reg >= 8'd200)      hund = 2'd2;
        else if (vx_reg >= 8'd100) hund = 2'd1;
        else                       hund = 2'd0;
        case (hund)
            2'd2:    rem100 = vx_reg - 8'd200;
            2'd1:    rem100 = vx_reg - 8'd100;
            default: rem100 = vx_reg;
        endcase
        tens_prod = {8'h00, rem100[6:0]} * 15'd205;
        tens      = tens_prod[14:11];
        ones      = 4'(rem100[6:0] - ({3'b000, tens} * 7'd10));
        case (cnt_reg[1:0])
            2'd0:    bcd_digit = {6'h0, hund};
            2'd1:    bcd_digit = {4'h0, tens};
            default: bcd_digit = {4'h0, ones};
        endcase
    end

    logic [12:0] addi_sum;
    logic [8:0]  add_sum;
    logic        key_sel;

    assign addi_sum = {1'b0, i_reg} + {5'h0, vx_reg};
    assign add_sum  = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign key_sel  = keys_reg[vx_reg[3:0]];

    always_comb
    begin
        pc_next   = pc_reg;
        i_next    = i_reg;
        sp_next   = sp_reg;
        dt_next   = dt_reg;
        st_next   = st_reg;
        keys_next = keys_reg;
        wait_next = wait_reg;
        tgt_next  = tgt_reg;
        cnt_next  = cnt_reg;
        opc_next  = opc_reg;
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        spr_next  = spr_reg;
        hit_next  = hit_reg;
        rf_we     = 1'b0;
        rf_waddr  = x;
        rf_wdata  = '0;
        rf_raddr  = x;
        vf_we     = 1'b0;
        vf_wdata  = '0;
        stk_we    = 1'b0;
        stk_waddr = sp_reg;
        stk_wdata = pc2;
        mem_re    = 1'b0;
        mem_raddr = pc_reg;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;

        case (cmd.step)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = (cnt_reg < 12'(FONT_BYTES)) ? font_byte(cnt_reg[6:0]) : 8'h00;
                cnt_next  = cnt_reg + 12'd1;
            end
            ST_DISPATCH:
            begin
                case (it_op_reg)
                    OP_TICK:
                    begin
                        if (dt_reg != 8'h00) dt_next = dt_reg - 8'd1;
                        if (st_reg != 8'h00) st_next = st_reg - 8'd1;
                    end
                    OP_KEY:
                    begin
                        keys_next[it_key_reg] = it_down_reg;
                        if (wait_reg && it_down_reg)
                        begin
                            rf_we     = 1'b1;
                            rf_waddr  = tgt_reg;
                            rf_wdata  = {4'h0, it_key_reg};
                            wait_next = 1'b0;
                        end
                    end
                    OP_WRITE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = it_addr_reg;
                        mem_wdata = it_byte_reg;
                    end
                    OP_READ:
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = it_addr_reg;
                    end
                    OP_SETPC: pc_next = it_addr_reg;
                    default: ;
                endcase
            end
            ST_F_HI:
            begin
                mem_re    = 1'b1;
                mem_raddr = pc_reg;
            end
            ST_F_LO:
            begin
                opc_next[15:8] = rd_q;
                mem_re         = 1'b1;
                mem_raddr      = pc_reg + 12'd1;
            end
            ST_F_DEC: opc_next[7:0] = rd_q;
            ST_VX:
            begin
                rf_raddr = x;
                vx_next  = rf_rdata;
            end
            ST_VY:
            begin
                rf_raddr = y;
                vy_next  = rf_rdata;
            end
            ST_EXEC:
            begin
                pc_next  = pc2;
                hit_next = 1'b0;
                cnt_next = (kind == K_DRAW) ? {8'h00, n - 4'd1} : 12'd0;
                case (op_hi)
                    OPG_SYS:
                    begin
                        if (nnn == NNN_RET)
                        begin
                            pc_next = stk_reg[sp_reg];
                            sp_next = sp_reg - 4'd1;
                        end
                    end
                    OPG_JP:   pc_next = nnn;
                    OPG_CALL:
                    begin
                        sp_next   = sp_reg + 4'd1;
                        stk_we    = 1'b1;
                        stk_waddr = sp_reg + 4'd1;
                        stk_wdata = pc2;
                        pc_next   = nnn;
                    end
                    OPG_SE:   if (vx_reg == kk) pc_next = pc4;
                    OPG_SNE:  if (vx_reg != kk) pc_next = pc4;
                    OPG_SEV:  if (n == 4'h0 && vx_reg == vy_reg) pc_next = pc4;
                    OPG_SNEV: if (n == 4'h0 && vx_reg != vy_reg) pc_next = pc4;
                    OPG_LD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = kk;
                    end
                    OPG_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = vx_reg + kk;
                    end
                    OPG_ALU:
                    begin
                        rf_we = 1'b1;
                        case (n)
                            ALU_MOV: rf_wdata = vy_reg;
                            ALU_OR:  rf_wdata = vx_reg | vy_reg;
                            ALU_AND: rf_wdata = vx_reg & vy_reg;
                            ALU_XOR: rf_wdata = vx_reg ^ vy_reg;
                            ALU_ADD:
                            begin
                                rf_wdata = add_sum[7:0];
                                vf_we    = 1'b1;
                                vf_wdata = {7'h0, add_sum[8]};
                            end
                            ALU_SUB:
                            begin
                                rf_wdata = vx_reg - vy_reg;
                                vf_we    = 1'b1;
                                vf_wdata = {7'h0, vx_reg >= vy_reg};
                            end
                            ALU_SHR:
                            begin
                                rf_wdata = {1'b0, vx_reg[7:1]};
                                vf_we    = 1'b1;
                                vf_wdata = {7'h0, vx_reg[0]};
                            end
                            ALU_SBN:
                            begin
                                rf_wdata = vy_reg - vx_reg;
                                vf_we    = 1'b1;
                                vf_wdata = {7'h0, vy_reg >= vx_reg};
                            end
                            ALU_SHL:
                            begin
                                rf_wdata = {vx_reg[6:0], 1'b0};
                                vf_we    = 1'b1;
                                vf_wdata = {7'h0, vx_reg[7]};
                            end
                            default: rf_we = 1'b0;
                        endcase
                    end
                    OPG_LDI:  i_next = nnn;
                    OPG_JPV:  pc_next = nnn + {4'h0, v_reg[0]};
                    OPG_RND:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = it_rnd_reg & kk;
                    end
                    OPG_DRW:
                    begin
                        // zero-row sprite only clears the flag
                        if (n == 4'h0)
                        begin
                            vf_we    = 1'b1;
                            vf_wdata = 8'h00;
                        end
                    end
                    OPG_KEY:
                    begin
                        if (kk == KK_SKP && key_sel)        pc_next = pc4;
                        else if (kk == KK_SKNP && !key_sel) pc_next = pc4;
                    end
                    OPG_MISC:
                    begin
                        case (kk)
                            KK_LDDT:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = dt_reg;
                            end
                            KK_WAITK:
                            begin
                                wait_next = 1'b1;
                                tgt_next  = x;
                            end
                            KK_SETDT: dt_next = vx_reg;
                            KK_SETST: st_next = vx_reg;
                            KK_ADDI:
                            begin
                                i_next   = addi_sum[11:0];
                                vf_we    = 1'b1;
                                vf_wdata = {7'h0, addi_sum[12]};
                            end
                            KK_FONT:  i_next = {2'b00, vx_reg, 2'b00} + {4'h0, vx_reg};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            ST_CLS:
            begin
                mem_we    = 1'b1;
                mem_waddr = DISP_BASE + {4'h0, cnt_reg[7:0]};
                mem_wdata = 8'h00;
                cnt_next  = cnt_reg + 12'd1;
            end
            ST_D_SPR:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg + cnt_reg;
            end
            ST_D_A:
            begin
                spr_next  = rd_q;
                mem_re    = 1'b1;
                mem_raddr = addr_a;
            end
            ST_D_AW:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_a;
                mem_wdata = rd_q ^ bits_a;
                hit_next  = hit_reg | (|(rd_q & bits_a));
                mem_re    = 1'b1;
                mem_raddr = addr_b;
            end
            ST_D_BW:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = rd_q ^ bits_b;
                hit_next  = hit_b;
                cnt_next  = cnt_reg - 12'd1;
                if (cnt_reg == 12'd0)
                begin
                    vf_we    = 1'b1;
                    vf_wdata = {7'h0, hit_b};
                end
            end
            ST_BCD:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg + cnt_reg;
                mem_wdata = bcd_digit;
                cnt_next  = cnt_reg + 12'd1;
            end
            ST_STORE:
            begin
                rf_raddr  = cnt_reg[3:0];
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = rf_rdata;
                i_next    = i_reg + 12'd1;
                cnt_next  = cnt_reg + 12'd1;
            end
            ST_LD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg;
            end
            ST_LD_WR:
            begin
                rf_we    = 1'b1;
                rf_waddr = cnt_reg[3:0];
                rf_wdata = rd_q;
                i_next   = i_reg + 12'd1;
                cnt_next = cnt_reg + 12'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k]   <= '0;
                stk_reg[k] <= '0;
            end
            pc_reg   <= '0;
            i_reg    <= '0;
            sp_reg   <= '0;
            dt_reg   <= '0;
            st_reg   <= '0;
            keys_reg <= '0;
            wait_reg <= 1'b0;
            tgt_reg  <= '0;
            cnt_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (rf_we && !(vf_we && rf_waddr == 4'hF)) v_reg[rf_waddr] <= rf_wdata;
            if (vf_we)  v_reg[15]          <= vf_wdata;   // flag wins over Vx
            if (stk_we) stk_reg[stk_waddr] <= stk_wdata;
            pc_reg   <= pc_next;
            i_reg    <= i_next;
            sp_reg   <= sp_next;
            dt_reg   <= dt_next;
            st_reg   <= st_next;
            keys_reg <= keys_next;
            wait_reg <= wait_next;
            tgt_reg  <= tgt_next;
            cnt_reg  <= cnt_next;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg <= opc_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        spr_reg <= spr_next;
        if (cmd.latch)
        begin
            it_op_reg   <= item_op_t'(op);
            it_key_reg  <= key_code;
            it_down_reg <= key_down;
            it_addr_reg <= mem_addr;
            it_byte_reg <= mem_byte;
            it_rnd_reg  <= random_byte;
        end
        if (cmd.out_load)
        begin
            rd_out_reg   <= (it_op_reg == OP_READ) ? rd_q : 8'h00;
            pc_out_reg   <= pc_reg;
            wait_out_reg <= wait_reg;
            snd_out_reg  <= (st_reg != 8'h00);
        end
    end

    assign status.item_op  = it_op_reg;
    assign status.waiting  = wait_reg;
    assign status.kind     = kind;
    assign status.clr_last = (cnt_reg == 12'(MEM_BYTES - 1));
    assign status.cls_last = (cnt_reg[7:0] == 8'hFF);
    assign status.cnt_zero = (cnt_reg == 12'd0);
    assign status.blk_last = (cnt_reg[3:0] == x);
    assign status.bcd_last = (cnt_reg[1:0] == 2'd2);

    assign read_data    = rd_out_reg;
    assign pc_value     = pc_out_reg;
    assign waiting      = wait_out_reg;
    assign sound_active = snd_out_reg;

endmodule

FILE: hdl/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: sequencer, datapath and checks.
//
// CHIP-8 interpreter core with 4 KiB of byte memory (font at 0-79, 64x32
// display at 80-335), sixteen V registers, I, PC, a 16-deep return stack,
// delay and sound timers and a 16-key keypad. Every transfer on the item
// channel yields exactly one transfer on the result channel. One item is
// handled at a time; the result sits in an output register, so the next
// item is taken while the previous result still waits for ready.
// Steps from the accepting edge to the result register load:
//   timer tick, key event, memory write/read, set PC, or execute while
//   waiting for a key: dispatch step only.
//   plain instruction: two memory fetch steps for the opcode bytes,
//   two register file reads for Vx and Vy, one execute step.
//   00E0: as plain, then 256 display bytes cleared, one per cycle.
//   Dxyn: as plain, then per row a sprite read and two display
//   read-modify-writes through the one memory.
//   Fx33/Fx55/Fx65: as plain, then 3 digit writes / x+1 stores / x+1 loads.
// After reset a pass over all 4096 memory bytes (font, then zeros)
// initializes the memory; no item is accepted during it.
module chip8_instruction_core
    import chip8_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    chip8_item_if.sink     item,
    chip8_result_if.source result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: owns handshakes and the step order
    chip8_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: all architectural state and the result register
    chip8_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (item.op),
        .key_code     (item.key_code),
        .key_down     (item.key_down),
        .mem_addr     (item.mem_addr),
        .mem_byte     (item.mem_byte),
        .random_byte  (item.random_byte),
        .read_data    (result.read_data),
        .pc_value     (result.pc_value),
        .waiting      (result.waiting),
        .sound_active (result.sound_active)
    );

    // No item taken while memory init runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step == ST_CLEAR |-> !item.ready)
        else $error("item ready during memory init");

    // One item at a time: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("second item accepted while busy");

    // Loading the result register presents a result next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result.valid)
        else $error("result load lost");

    // Result register is never overwritten while its content is held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !result.valid || result.ready)
        else $error("result overwritten before transfer");

endmodule

FILE: tb/sv/chip8_core_checker.sv
// Watches both channels of the CHIP-8 core, predicts every result and compares.
module chip8_core_checker
    import chip8_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    chip8_item_if   item,
    chip8_result_if result,
    output int      fail_count,
    output int      outstanding
);

    typedef struct packed {
        logic [7:0]  read_data;
        logic [11:0] pc_value;
        logic        waiting;
        logic        sound_active;
    } core_view_t;

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  vreg [16];
    logic [11:0] ireg;
    logic [11:0] pc;
    logic [11:0] stack [16];
    logic [3:0]  sp;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;
    logic        key_state [16];
    logic        key_wait;
    logic [3:0]  key_dest;
    core_view_t  view_q [$];

    function automatic void power_up();
        for (int a = 0; a < MEM_BYTES; a++) begin
            mem[a] = '0;
        end
        for (int g = 0; g < 16; g++) begin
            for (int r = 0; r < 5; r++) begin
                mem[g * 5 + r] = {GLYPH[g][19 - 4 * r -: 4], 4'h0};
            end
            vreg[g] = '0;
            stack[g] = '0;
            key_state[g] = 1'b0;
        end
        ireg = '0;
        pc = '0;
        sp = '0;
        delay_cnt = '0;
        sound_cnt = '0;
        key_wait = 1'b0;
        key_dest = '0;
    endfunction

    // XOR one byte into the display, return the lit bits it cleared
    function automatic logic [7:0] plot(input int cell_idx, input logic [7:0] bits);
        int a;
        logic [7:0] old;
        a = DISP_BASE + (cell_idx % 256);
        old = mem[a];
        mem[a] = old ^ bits;
        return old & bits;
    endfunction

    function automatic void run_instr(input logic [7:0] rnd);
        logic [15:0] opc;
        logic [11:0] nnn;
        logic [7:0]  kk, vx, vy;
        logic [3:0]  x, y, n;
        logic [8:0]  sum;
        logic [12:0] isum;
        logic [7:0]  hit, spr;
        int row, px, sh;
        opc = {mem[pc], mem[12'(pc + 1)]};
        nnn = opc[11:0];
        kk = opc[7:0];
        x = opc[11:8];
        y = opc[7:4];
        n = opc[3:0];
        vx = vreg[x];
        vy = vreg[y];
        pc = pc + 12'd2;
        case (opc[15:12])
            OPG_SYS: begin
                if (nnn == NNN_CLS) begin
                    for (int a = 0; a < 256; a++) mem[DISP_BASE + a] = '0;
                end else if (nnn == NNN_RET) begin
                    pc = stack[sp];
                    sp = sp - 4'd1;
                end
            end
            OPG_JP:   pc = nnn;
            OPG_CALL: begin
                sp = sp + 4'd1;
                stack[sp] = pc;
                pc = nnn;
            end
            OPG_SE:   if (vx == kk) pc = pc + 12'd2;
            OPG_SNE:  if (vx != kk) pc = pc + 12'd2;
            OPG_SEV:  if (n == 0 && vx == vy) pc = pc + 12'd2;
            OPG_LD:   vreg[x] = kk;
            OPG_ADD:  vreg[x] = vx + kk;
            OPG_ALU: begin
                // result first, flag last so VF as target ends with the flag
                case (n)
                    ALU_MOV: vreg[x] = vy;
                    ALU_OR:  vreg[x] = vx | vy;
                    ALU_AND: vreg[x] = vx & vy;
                    ALU_XOR: vreg[x] = vx ^ vy;
                    ALU_ADD: begin
                        sum = vx + vy;
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    ALU_SUB: begin
                        vreg[x] = vx - vy;
                        vreg[15] = {7'd0, vx >= vy};
                    end
                    ALU_SHR: begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    ALU_SBN: begin
                        vreg[x] = vy - vx;
                        vreg[15] = {7'd0, vy >= vx};
                    end
                    ALU_SHL: begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: ;
                endcase
            end
            OPG_SNEV: if (n == 0 && vx != vy) pc = pc + 12'd2;
            OPG_LDI:  ireg = nnn;
            OPG_JPV:  pc = nnn + {4'd0, vreg[0]};
            OPG_RND:  vreg[x] = rnd & kk;
            OPG_DRW: begin
                hit = '0;
                px = vx;
                sh = px % 8;
                for (int i = int'(n) - 1; i >= 0; i--) begin
                    row = ((int'(vy) + i) % 32) * 64;
                    spr = mem[12'(ireg + i)];
                    hit |= plot(((px % 64) + row) / 8, spr >> sh);
                    hit |= plot((((px + 8) % 64) + row) / 8, 8'(16'(spr) << (8 - sh)));
                end
                vreg[15] = {7'd0, hit != 0};
            end
            OPG_KEY: begin
                if (kk == KK_SKP && key_state[vx[3:0]]) pc = pc + 12'd2;
                else if (kk == KK_SKNP && !key_state[vx[3:0]]) pc = pc + 12'd2;
            end
            OPG_MISC: begin
                case (kk)
                    KK_LDDT:  vreg[x] = delay_cnt;
                    KK_WAITK: begin
                        key_wait = 1'b1;
                        key_dest = x;
                    end
                    KK_SETDT: delay_cnt = vx;
                    KK_SETST: sound_cnt = vx;
                    KK_ADDI: begin
                        isum = ireg + vx;
                        ireg = isum[11:0];
                        vreg[15] = {7'd0, isum[12]};
                    end
                    KK_FONT:  ireg = 12'(vx * 5);
                    KK_BCD: begin
                        mem[ireg] = vx / 100;
                        mem[12'(ireg + 1)] = (vx / 10) % 10;
                        mem[12'(ireg + 2)] = vx % 10;
                    end
                    KK_STORE: begin
                        for (int i = 0; i <= int'(x); i++) begin
                            mem[ireg] = vreg[i];
                            ireg = ireg + 12'd1;
                        end
                    end
                    KK_LOAD: begin
                        for (int i = 0; i <= int'(x); i++) begin
                            vreg[i] = mem[ireg];
                            ireg = ireg + 12'd1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic core_view_t apply_item(input logic [2:0] op, input logic [3:0] key,
                                              input logic down, input logic [11:0] addr,
                                              input logic [7:0] data, input logic [7:0] rnd);
        core_view_t r;
        r.read_data = '0;
        case (op)
            OP_EXEC:  if (!key_wait) run_instr(rnd);
            OP_TICK: begin
                if (delay_cnt != 0) delay_cnt--;
                if (sound_cnt != 0) sound_cnt--;
            end
            OP_KEY: begin
                key_state[key] = down;
                if (key_wait && down) begin
                    vreg[key_dest] = {4'd0, key};
                    key_wait = 1'b0;
                end
            end
            OP_WRITE: mem[addr] = data;
            OP_READ:  r.read_data = mem[addr];
            OP_SETPC: pc = addr;
            default: ;
        endcase
        r.pc_value = pc;
        r.waiting = key_wait;
        r.sound_active = sound_cnt != 0;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    assign outstanding = view_q.size();

    always @(posedge clk or negedge rst_n) begin
        core_view_t want;
        if (!rst_n) begin
            power_up();
            view_q.delete();
            fail_count = 0;
        end else begin
            if (result.valid && result.ready) begin
                if (view_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual pc %0h",
                             $time, result.pc_value);
                    fail_count++;
                end else begin
                    want = view_q.pop_front();
                    check_field("read_data", want.read_data, result.read_data);
                    check_field("pc_value", want.pc_value, result.pc_value);
                    check_field("waiting", want.waiting, result.waiting);
                    check_field("sound_active", want.sound_active, result.sound_active);
                end
            end
            if (item.valid && item.ready) begin
                view_q.push_back(apply_item(item.op, item.key_code, item.key_down,
                                            item.mem_addr, item.mem_byte, item.random_byte));
            end
        end
    end

endmodule

FILE: tb/sv/chip8_instruction_core_test.sv
// Stimulus and verdict for the CHIP-8 instruction core.
module chip8_instruction_core_test
    import chip8_pkg::*;
();

    localparam int ITEM_GOAL  = 1850;
    localparam int CALM_AFTER = 1650;   // no idling past this many items
    localparam int IDLE_LIMIT = 30000;  // covers the clear pass over all 4096 bytes after reset

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   items_sent;
    int   idle_cycles;
    bit   calm;

    chip8_item_if   item ();
    chip8_result_if result ();

    chip8_instruction_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    chip8_core_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side backpressure: random stall bursts, none once calm
    int stall_left;
    always @(posedge clk)
    begin
        if (!rst_n) begin
            result.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0 && !calm) begin
            result.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            result.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 14);
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One transfer on the item channel; valid stays high into the next call unless a random pause drops it
    task automatic send(input logic [2:0] op, input logic [3:0] key, input logic down,
                        input logic [11:0] addr, input logic [7:0] data,
                        input logic [7:0] rnd);
        item.valid       <= 1'b1;
        item.op          <= op;
        item.key_code    <= key;
        item.key_down    <= down;
        item.mem_addr    <= addr;
        item.mem_byte    <= data;
        item.random_byte <= rnd;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        items_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic put_byte(input logic [11:0] addr, input logic [7:0] data);
        send(OP_WRITE, $urandom, $urandom, addr, data, $urandom);
    endtask

    task automatic put_word(input logic [11:0] addr, input logic [15:0] w);
        put_byte(addr, w[15:8]);
        put_byte(addr + 12'd1, w[7:0]);
    endtask

    task automatic step(input logic [7:0] rnd);
        send(OP_EXEC, $urandom, $urandom, $urandom, $urandom, rnd);
    endtask

    // Random instruction word, every group and sub-operation reachable
    function automatic logic [15:0] random_instr();
        logic [3:0]  x, y;
        logic [15:0] w;
        logic [7:0]  misc_kk [11] = '{KK_LDDT, KK_WAITK, KK_SETDT, KK_SETST, KK_ADDI,
                                      KK_FONT, KK_BCD, KK_STORE, KK_LOAD, 8'h00, 8'hFF};
        logic [3:0]  alu_n [10] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                                    ALU_SHR, ALU_SBN, ALU_SHL, 4'h9};
        x = $urandom;
        y = $urandom;
        w = $urandom;
        case ($urandom_range(0, 19))
            0:  w = ($urandom_range(0, 7) == 0) ? {OPG_SYS, NNN_CLS} :
                    ($urandom_range(0, 1) ? {OPG_SYS, NNN_RET} : {OPG_SYS, w[11:0]});
            1:  w = {OPG_JP, w[11:0]};
            2:  w = {OPG_CALL, w[11:0]};
            3:  w = {$urandom_range(0, 1) ? OPG_SE : OPG_SNE, x, w[7:0]};
            4:  w = {$urandom_range(0, 1) ? OPG_SEV : OPG_SNEV, x, y,
                     $urandom_range(0, 3) == 0 ? w[3:0] : 4'h0};
            5, 6: w = {OPG_LD, x, w[7:0]};
            7:  w = {OPG_ADD, x, w[7:0]};
            8, 9: w = {OPG_ALU, x, y, alu_n[$urandom_range(0, 9)]};
            10: w = {OPG_LDI, w[11:0]};
            11: w = {OPG_JPV, w[11:0]};
            12: w = {OPG_RND, x, w[7:0]};
            13: w = {OPG_DRW, x, y, w[3:0]};
            14: w = {OPG_KEY, x, $urandom_range(0, 4) == 0 ? w[7:0] :
                     ($urandom_range(0, 1) ? KK_SKP : KK_SKNP)};
            15, 16, 17: w = {OPG_MISC, x, misc_kk[$urandom_range(0, 10)]};
            default: ;  // fully random word
        endcase
        return w;
    endfunction

    initial
    begin
        logic [11:0] base;
        int len;
        items_sent = 0;
        idle_cycles = 0;
        calm = 1'b0;
        item.valid <= 1'b0;
        item.op <= OP_EXEC;
        item.key_code <= '0;
        item.key_down <= 1'b0;
        item.mem_addr <= '0;
        item.mem_byte <= '0;
        item.random_byte <= '0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: font readback, address extremes, unused op codes
        send(OP_READ, 4'h0, 1'b0, 12'd0, 8'h00, 8'h00);
        send(OP_READ, 4'hF, 1'b1, 12'd79, 8'hFF, 8'hFF);
        put_byte(12'hFFF, 8'hFF);
        send(OP_READ, 4'h0, 1'b0, 12'hFFF, 8'h00, 8'h00);
        send(3'd6, 4'hF, 1'b1, 12'hFFF, 8'hFF, 8'hFF);
        send(3'd7, 4'h0, 1'b0, 12'h000, 8'h00, 8'h00);
        // Opcode straddling the top of memory: FF xx, then set sound timer
        put_byte(12'h000, 8'h18);
        send(OP_SETPC, 4'h0, 1'b0, 12'hFFF, 8'h00, 8'h00);
        step(8'hFF);
        send(OP_TICK, 4'h0, 1'b0, 12'h000, 8'h00, 8'h00);
        // Flag register as target of an add with carry, then key wait
        put_word(12'h200, {OPG_LD, 4'hF, 8'hFF});
        put_word(12'h202, {OPG_ALU, 4'hF, 4'hF, ALU_ADD});
        put_word(12'h204, {OPG_MISC, 4'h3, KK_WAITK});
        send(OP_SETPC, 4'h0, 1'b0, 12'h200, 8'h00, 8'h00);
        repeat (4) step(8'hA5);
        send(OP_KEY, 4'hF, 1'b0, 12'h000, 8'h00, 8'h00);
        send(OP_KEY, 4'hF, 1'b1, 12'h000, 8'h00, 8'h00);

        // Random: short programs with random content, plus noise items
        while (items_sent < ITEM_GOAL) begin
            if (items_sent >= CALM_AFTER) calm = 1'b1;
            if ($urandom_range(0, 5) == 0) begin
                send($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                base = $urandom;
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) put_word(base + 12'(2 * i), random_instr());
                send(OP_SETPC, $urandom, $urandom, base, $urandom, $urandom);
                for (int i = 0; i < len + 2; i++) begin
                    case ($urandom_range(0, 9))
                        0: send(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
                        1: send(OP_KEY, $urandom, $urandom, $urandom, $urandom, $urandom);
                        default: step($urandom);
                    endcase
                end
            end
        end

        item.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
